>>> design/wmf_pkg.sv
// wmf_pkg: shared types and constants of the window median filter
// depends on nothing; used by wmf_select, the filter core and the testbench
`timescale 1ns / 1ps
`default_nettype none

package wmf_pkg;

  localparam int LINE_MAX   = 1024;
  localparam int HALF_MAX   = 3;
  localparam int PIXEL_BITS = 8;
  localparam int ROW_MAX    = 1024;
  localparam int CFG_BITS   = 11;

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_HALF   = 2'd2;

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef struct packed {
    logic                  cmd;
    logic [PIXEL_BITS-1:0] pixel_in;
  } in_word_t;

  typedef struct packed {
    logic                  [PIXEL_BITS-1:0] median_out;
    logic                  last_of_run;
    logic                  end_of_frame;
  } out_word_t;

endpackage

`default_nettype wire

>>> design/wmf_ram.sv
// wmf_ram: generic simple dual port ram, one write and one registered read port
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

module wmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> design/wmf_select.sv
// wmf_select: bitwise rank selection over a window read from the line store
// one sweep of the window per pixel bit, msb first; depends on wmf_pkg
`timescale 1ns / 1ps
`default_nettype none

module wmf_select #(
  parameter int LINE_MAX = wmf_pkg::LINE_MAX,
  parameter int HALF_MAX = wmf_pkg::HALF_MAX,
  localparam int S  = 2 * HALF_MAX + 1,
  localparam int SB = $clog2(S),
  localparam int CB = $clog2(LINE_MAX),
  localparam int RB = $clog2(wmf_pkg::ROW_MAX),
  localparam int NB = $clog2(S * S + 1),
  localparam int PB = wmf_pkg::PIXEL_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [RB-1:0] row_lo,
  input  wire logic [RB-1:0] row_hi,
  input  wire logic [CB-1:0] col_lo,
  input  wire logic [CB-1:0] col_hi,
  input  wire logic [SB-1:0] slot_lo,
  input  wire logic [NB-1:0] rank,
  output      logic          rd_en,
  output      logic [SB+CB-1:0] rd_addr,
  input  wire logic [PB-1:0] rd_data,
  output      logic          done,
  output      logic [PB-1:0] result
);

  typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_TAIL} sel_state_t;

  sel_state_t    state_r;
  logic [RB-1:0] row_r, r0_r, r1_r;
  logic [CB-1:0] col_r, c0_r, c1_r;
  logic [SB-1:0] slot_r, s0_r;
  logic [NB-1:0] k_r, cnt_r;
  logic [PB-1:0] bit_r, hi_r, pre_r;
  logic          vld_r;
  logic          hit;
  logic [NB-1:0] cnt_sum;
  logic          last_issue;

  // value counts if it shares the prefix above this bit and has this bit low
  assign hit = vld_r && (((rd_data ^ pre_r) & hi_r) == '0) && ((rd_data & bit_r) == '0);
  assign cnt_sum = cnt_r + NB'(hit);
  assign last_issue = (row_r == r1_r) && (col_r == c1_r);
  assign rd_en = (state_r == ST_SWEEP);
  assign rd_addr = {slot_r, col_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      vld_r   <= 1'b0;
      done    <= 1'b0;
    end else begin
      done  <= 1'b0;
      vld_r <= (state_r == ST_SWEEP);
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            r0_r <= row_lo;  r1_r <= row_hi;
            c0_r <= col_lo;  c1_r <= col_hi;
            s0_r <= slot_lo; k_r <= rank;
            row_r <= row_lo; col_r <= col_lo; slot_r <= slot_lo;
            bit_r <= {1'b1, {(PB-1){1'b0}}};
            hi_r  <= '0;
            pre_r <= '0;
            cnt_r <= '0;
            state_r <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          cnt_r <= cnt_sum;
          if (col_r == c1_r) begin
            col_r <= c0_r;
            row_r <= row_r + RB'(1);
            slot_r <= (slot_r == SB'(S - 1)) ? '0 : slot_r + SB'(1);
          end else begin
            col_r <= col_r + CB'(1);
          end
          if (last_issue) begin
            state_r <= ST_TAIL;
          end
        end
        ST_TAIL: begin
          if (k_r >= cnt_sum) begin
            pre_r <= pre_r | bit_r;
            k_r   <= k_r - cnt_sum;
          end
          cnt_r <= '0;
          hi_r  <= hi_r | bit_r;
          bit_r <= bit_r >> 1;
          row_r <= r0_r; col_r <= c0_r; slot_r <= s0_r;
          if (bit_r[0]) begin
            done    <= 1'b1;
            state_r <= ST_IDLE;
          end else begin
            state_r <= ST_SWEEP;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign result = pre_r;

endmodule

`default_nettype wire

>>> design/window_median_filter_core.sv
// Operation: a push writes the line store in its accept cycle; each result then comes
// from a rank select over its window, window pixels up to (2*half+1)^2, which sweeps
// the window once per pixel bit through one ram read port.
// Throughput: one item at a time; a push may release up to HALF_MAX+1 results.
// Reset (rst_n, synchronous): registers 1024/1024/2, frame positions cleared;
// the line store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module window_median_filter_core #(
  parameter int LINE_MAX = wmf_pkg::LINE_MAX,
  parameter int HALF_MAX = wmf_pkg::HALF_MAX
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire wmf_pkg::in_word_t  in_word,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      wmf_pkg::out_word_t out_word,
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [wmf_pkg::CFG_BITS-1:0] cfg_data
);

  localparam int S  = 2 * HALF_MAX + 1;
  localparam int SB = $clog2(S);
  localparam int CB = $clog2(LINE_MAX);
  localparam int RB = $clog2(wmf_pkg::ROW_MAX);
  localparam int HB = $clog2(HALF_MAX + 1);
  localparam int DB = $clog2(S + 1);
  localparam int NB = $clog2(S * S + 1);
  localparam int LB = $clog2(HALF_MAX + 2);
  localparam int PB = wmf_pkg::PIXEL_BITS;
  localparam int CW = wmf_pkg::CFG_BITS;
  localparam int EB = ($clog2(LINE_MAX + 1) > CW) ? $clog2(LINE_MAX + 1) : CW;

  typedef enum logic [1:0] {ST_IDLE, ST_CHECK, ST_RUN, ST_EMIT} top_state_t;

  top_state_t    state_r;
  logic [CW-1:0] width_r, height_r;
  logic [1:0]    half_r;
  logic [CB-1:0] in_col_r, out_col_r;
  logic [RB-1:0] in_row_r, out_row_r;
  logic [SB-1:0] in_slot_r, out_slot_r;
  logic          in_done_r;
  logic [LB-1:0] lim_r, n_r;
  logic [PB-1:0] med_r;
  logic          eof_r;

  // effective geometry
  logic [EB-1:0] w_ext;
  logic [CB-1:0] wl;
  logic [RB-1:0] hl;
  logic [HB-1:0] h;
  always_comb begin
    w_ext = EB'(width_r);
    if (w_ext == '0) wl = '0;
    else if (w_ext > EB'(LINE_MAX)) wl = CB'(LINE_MAX - 1);
    else wl = CB'(w_ext - EB'(1));
    if (height_r == '0) hl = '0;
    else if (height_r > CW'(wmf_pkg::ROW_MAX)) hl = RB'(wmf_pkg::ROW_MAX - 1);
    else hl = RB'(height_r - CW'(1));
    h = (half_r > HALF_MAX) ? HB'(HALF_MAX) : HB'(half_r);
  end

  // window bounds around the current output position
  logic [RB:0]   r_up, lr;
  logic [CB:0]   c_up, lc;
  logic [RB-1:0] r0;
  logic [CB-1:0] c0;
  logic          ready_win;
  always_comb begin
    r_up = {1'b0, out_row_r} + (RB+1)'(h);
    c_up = {1'b0, out_col_r} + (CB+1)'(h);
    lr = (r_up > {1'b0, hl}) ? {1'b0, hl} : r_up;
    lc = (c_up > {1'b0, wl}) ? {1'b0, wl} : c_up;
    r0 = (out_row_r >= RB'(h)) ? out_row_r - RB'(h) : '0;
    c0 = (out_col_r >= CB'(h)) ? out_col_r - CB'(h) : '0;
    ready_win = in_done_r || (lr < {1'b0, in_row_r}) ||
                ((lr == {1'b0, in_row_r}) && (lc < {1'b0, in_col_r}));
  end

  logic [HB-1:0] dr_up;
  logic [SB-1:0] slot0;
  logic [DB-1:0] nrows, ncols;
  logic [NB-1:0] npix;
  always_comb begin
    dr_up = HB'(out_row_r - r0);
    slot0 = (out_slot_r >= SB'(dr_up)) ? out_slot_r - SB'(dr_up)
                                       : SB'(out_slot_r + SB'(S) - SB'(dr_up));
    nrows = DB'(lr[RB-1:0] - r0) + DB'(1);
    ncols = DB'(lc[CB-1:0] - c0) + DB'(1);
    npix  = NB'(nrows) * NB'(ncols);
  end

  logic          in_acc, cfg_acc, push;
  logic          sel_done;
  logic [PB-1:0] sel_result;
  logic          rd_en;
  logic [SB+CB-1:0] rd_addr;
  logic [PB-1:0] rd_data;
  logic          more;

  assign cfg_ready = (state_r == ST_IDLE);
  assign in_stall  = (state_r != ST_IDLE) || cfg_valid;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign push      = in_acc && (in_word.cmd == wmf_pkg::CMD_PUSH) && !in_done_r;
  assign more      = ((n_r + LB'(1)) < lim_r) && ready_win;

  assign out_valid = (state_r == ST_EMIT);
  assign out_word  = '{median_out: med_r, last_of_run: !more, end_of_frame: eof_r};

  wmf_ram #(.WIDTH(PB), .DEPTH(S << CB)) u_line_store (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr ({in_slot_r, in_col_r}),
    .wr_data (in_word.pixel_in),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  wmf_select #(.LINE_MAX(LINE_MAX), .HALF_MAX(HALF_MAX)) u_select (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   ((state_r == ST_CHECK) && ready_win),
    .row_lo  (r0),
    .row_hi  (lr[RB-1:0]),
    .col_lo  (c0),
    .col_hi  (lc[CB-1:0]),
    .slot_lo (slot0),
    .rank    (npix >> 1),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .done    (sel_done),
    .result  (sel_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      width_r    <= CW'(1024);
      height_r   <= CW'(1024);
      half_r     <= 2'd2;
      in_col_r   <= '0; in_row_r  <= '0; in_slot_r  <= '0;
      out_col_r  <= '0; out_row_r <= '0; out_slot_r <= '0;
      in_done_r  <= 1'b0;
      lim_r      <= '0;
      n_r        <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (cfg_acc && (cfg_index == wmf_pkg::REG_WIDTH || cfg_index == wmf_pkg::REG_HEIGHT ||
                          cfg_index == wmf_pkg::REG_HALF)) begin
            case (cfg_index)
              wmf_pkg::REG_WIDTH:  width_r  <= cfg_data;
              wmf_pkg::REG_HEIGHT: height_r <= cfg_data;
              default:             half_r   <= cfg_data[1:0];
            endcase
            in_col_r  <= '0; in_row_r  <= '0; in_slot_r  <= '0;
            out_col_r <= '0; out_row_r <= '0; out_slot_r <= '0;
            in_done_r <= 1'b0;
          end else if (in_acc) begin
            n_r   <= '0;
            lim_r <= push ? LB'(HALF_MAX + 1) : LB'(1);
            if (push) begin
              if (in_col_r == wl) begin
                in_col_r <= '0;
                if (in_row_r == hl) begin
                  in_row_r  <= '0;
                  in_slot_r <= '0;
                  in_done_r <= 1'b1;
                end else begin
                  in_row_r  <= in_row_r + RB'(1);
                  in_slot_r <= (in_slot_r == SB'(S - 1)) ? '0 : in_slot_r + SB'(1);
                end
              end else begin
                in_col_r <= in_col_r + CB'(1);
              end
            end
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          eof_r   <= (out_row_r == hl) && (out_col_r == wl);
          state_r <= ready_win ? ST_RUN : ST_IDLE;
        end
        ST_RUN: begin
          if (sel_done) begin
            med_r <= sel_result;
            if (eof_r) begin
              out_col_r <= '0; out_row_r <= '0; out_slot_r <= '0;
              in_done_r <= 1'b0;
            end else if (out_col_r == wl) begin
              out_col_r  <= '0;
              out_row_r  <= out_row_r + RB'(1);
              out_slot_r <= (out_slot_r == SB'(S - 1)) ? '0 : out_slot_r + SB'(1);
            end else begin
              out_col_r <= out_col_r + CB'(1);
            end
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_stall) begin
            n_r     <= n_r + LB'(1);
            state_r <= more ? ST_CHECK : ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // a finished selection always shows up as a result in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n) sel_done |=> out_valid)
    else $error("selection finished without a result");

  // no result is offered while new input can be taken
  assert property (@(posedge clk) disable iff (!rst_n) !(out_valid && !in_stall))
    else $error("result offered while input open");

  // configuration and input never accepted together
  assert property (@(posedge clk) disable iff (!rst_n) !(cfg_acc && in_acc))
    else $error("config write collided with input word");

  // an accepted word always leads to a window check
  assert property (@(posedge clk) disable iff (!rst_n) in_acc |=> state_r == ST_CHECK)
    else $error("accepted word not processed");

endmodule

`default_nettype wire

>>> tb/testbench.sv
// testbench: self-checking bench for window_median_filter_core
// depends on wmf_pkg and the filter core; predicts every result and compares in order
`timescale 1ns / 1ps
`default_nettype none

module testbench;

  localparam int LINE_MAX = wmf_pkg::LINE_MAX;
  localparam int HALF_MAX = wmf_pkg::HALF_MAX;
  localparam int ROW_MAX = wmf_pkg::ROW_MAX;
  localparam int PB = wmf_pkg::PIXEL_BITS;
  localparam int CW = wmf_pkg::CFG_BITS;
  localparam int STORE_ROWS = 2 * HALF_MAX + 1;
  localparam int QUIET_CYCLES = 600;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  wmf_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  wmf_pkg::out_word_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [CW-1:0] cfg_data = '0;

  window_median_filter_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // predictor state
  logic [PB-1:0] pix_store [STORE_ROWS*LINE_MAX];
  logic [CW-1:0] reg_width, reg_height;
  logic [1:0] reg_half;
  int unsigned in_c, in_r, out_c, out_r;
  bit frame_in_done;
  wmf_pkg::out_word_t median_q[$];

  int errors = 0;
  int items_sent = 0;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int hold_ask = 0;
  int hold_left = 0;
  longint cycles = 0;

  function automatic int unsigned width_eff();
    if (reg_width == 0) return 1;
    if (reg_width > LINE_MAX) return LINE_MAX;
    return reg_width;
  endfunction

  function automatic int unsigned height_eff();
    if (reg_height == 0) return 1;
    if (reg_height > ROW_MAX) return ROW_MAX;
    return reg_height;
  endfunction

  function automatic int unsigned half_eff();
    return (reg_half > HALF_MAX) ? HALF_MAX : reg_half;
  endfunction

  function automatic int unsigned pix_addr(int unsigned r, int unsigned c);
    return (r % STORE_ROWS) * LINE_MAX + (c % LINE_MAX);
  endfunction

  function automatic bit pixel_arrived(int unsigned r, int unsigned c);
    if (frame_in_done) return 1'b1;
    return (r < in_r) || (r == in_r && c < in_c);
  endfunction

  function automatic logic [PB-1:0] window_median(int unsigned r, int unsigned c,
      int unsigned wd, int unsigned ht, int unsigned hf);
    logic [PB-1:0] vals [STORE_ROWS*STORE_ROWS];
    logic [PB-1:0] v;
    int unsigned r0, r1, c0, c1, cnt;
    int j;
    r0 = (r >= hf) ? r - hf : 0;
    c0 = (c >= hf) ? c - hf : 0;
    r1 = (r + hf > ht - 1) ? ht - 1 : r + hf;
    c1 = (c + hf > wd - 1) ? wd - 1 : c + hf;
    cnt = 0;
    for (int unsigned i = r0; i <= r1; i++)
      for (int unsigned k = c0; k <= c1; k++) begin
        vals[cnt] = pix_store[pix_addr(i, k)];
        cnt++;
      end
    for (int i = 1; i < cnt; i++) begin
      v = vals[i];
      j = i;
      while (j > 0 && vals[j-1] > v) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = v;
    end
    return vals[cnt / 2];
  endfunction

  function automatic void restart_frame();
    in_c = 0; in_r = 0; out_c = 0; out_r = 0;
    frame_in_done = 1'b0;
  endfunction

  function automatic void predict_medians(wmf_pkg::in_word_t iw);
    int unsigned wd, ht, hf, lr, lc;
    int lim, n;
    bit eof;
    wmf_pkg::out_word_t res;
    wd = width_eff(); ht = height_eff(); hf = half_eff();
    lim = 1;
    n = 0;
    if (iw.cmd == wmf_pkg::CMD_PUSH && !frame_in_done) begin
      pix_store[pix_addr(in_r, in_c)] = iw.pixel_in;
      in_c++;
      if (in_c >= wd) begin
        in_c = 0;
        in_r++;
        if (in_r >= ht) begin
          in_r = 0;
          frame_in_done = 1'b1;
        end
      end
      lim = HALF_MAX + 1;
    end
    while (n < lim) begin
      lr = (out_r + hf > ht - 1) ? ht - 1 : out_r + hf;
      lc = (out_c + hf > wd - 1) ? wd - 1 : out_c + hf;
      if (!pixel_arrived(lr, lc)) break;
      eof = (out_r == ht - 1) && (out_c == wd - 1);
      res.median_out = window_median(out_r, out_c, wd, ht, hf);
      res.last_of_run = 1'b0;
      res.end_of_frame = eof;
      median_q.insert(median_q.size(), res);
      n++;
      if (eof) begin
        out_r = 0; out_c = 0;
        frame_in_done = 1'b0;
      end else begin
        out_c++;
        if (out_c >= wd) begin
          out_c = 0;
          out_r++;
        end
      end
    end
    if (n > 0) median_q[median_q.size()-1].last_of_run = 1'b1;
  endfunction

  // result checker and receiver stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (median_q.size() == 0) begin
        $error("unexpected word: median_out %0d", out_word.median_out);
        errors++;
      end else begin
        if (out_word.median_out !== median_q[0].median_out) begin
          $error("median_out expected %0d actual %0d", median_q[0].median_out,
                 out_word.median_out);
          errors++;
        end
        if (out_word.last_of_run !== median_q[0].last_of_run) begin
          $error("last_of_run expected %0d actual %0d", median_q[0].last_of_run,
                 out_word.last_of_run);
          errors++;
        end
        if (out_word.end_of_frame !== median_q[0].end_of_frame) begin
          $error("end_of_frame expected %0d actual %0d", median_q[0].end_of_frame,
                 out_word.end_of_frame);
          errors++;
        end
        void'(median_q.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    if (hold_ask > 0) begin
      hold_left = hold_ask;
      hold_ask = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_word(logic cmd, logic [PB-1:0] pix);
    wmf_pkg::in_word_t iw;
    iw.cmd = cmd;
    iw.pixel_in = pix;
    while ($urandom_range(99) < in_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_word <= iw;
    do @(posedge clk); while (in_stall);
    predict_medians(iw);
    items_sent++;
  endtask

  task automatic park_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // all results in, then let a result-less item finish
  task automatic wait_quiet();
    park_input();
    wait (median_q.size() == 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      wmf_pkg::REG_WIDTH:  reg_width = val;
      wmf_pkg::REG_HEIGHT: reg_height = val;
      wmf_pkg::REG_HALF:   reg_half = val[1:0];
      default: ;
    endcase
    restart_frame();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_frame(logic [CW-1:0] wd, logic [CW-1:0] ht, logic [1:0] hf);
    wait_quiet();
    write_reg(wmf_pkg::REG_WIDTH, wd);
    write_reg(wmf_pkg::REG_HEIGHT, ht);
    write_reg(wmf_pkg::REG_HALF, CW'(hf));
  endtask

  function automatic bit frame_pending();
    return frame_in_done || out_r != 0 || out_c != 0;
  endfunction

  task automatic test_directed();
    // 3x3 frame, widest window, extremes; extra pushes after input act as drains
    set_frame(3, 3, 3);
    send_word(wmf_pkg::CMD_DRAIN, 8'h5a);
    for (int i = 0; i < 9; i++)
      send_word(wmf_pkg::CMD_PUSH, (i % 2) ? 8'hff : 8'h00);
    send_word(wmf_pkg::CMD_PUSH, 8'h77);
    while (frame_pending()) send_word(wmf_pkg::CMD_DRAIN, 8'hff);
    // zero sizes read as one pixel, half zero
    set_frame(0, 0, 0);
    send_word(wmf_pkg::CMD_PUSH, 8'hff);
    send_word(wmf_pkg::CMD_DRAIN, 8'h00);
    // oversize width saturates, partial frame then restart
    set_frame(11'h7ff, 2, 1);
    for (int i = 0; i < 6; i++) send_word(wmf_pkg::CMD_PUSH, PB'(8'h80 + i));
    // oversize height saturates, one column, partial
    set_frame(1, 11'h7ff, 3);
    for (int i = 0; i < 6; i++) send_word(wmf_pkg::CMD_PUSH, 8'h01 << i);
    set_frame(1024, 1024, 2);
  endtask

  task automatic test_random_frames(int target);
    int stop_at, wd, ht, npix;
    stop_at = items_sent + target;
    while (items_sent < stop_at) begin
      wd = ($urandom_range(9) == 0) ? $urandom_range(1024, 40) : $urandom_range(12, 1);
      ht = (wd > 12) ? 1 : $urandom_range(8, 1);
      set_frame(CW'(wd), CW'(ht), 2'($urandom_range(3)));
      npix = wd * ht;
      if ($urandom_range(9) == 0) npix = $urandom_range(npix);
      if (wd > 12) npix = (npix > 20) ? 20 : npix;
      for (int i = 0; i < npix; i++) begin
        if ($urandom_range(9) == 0) send_word(wmf_pkg::CMD_DRAIN, PB'($urandom));
        send_word(wmf_pkg::CMD_PUSH, PB'($urandom));
      end
      if (npix == wd * ht)
        while (frame_pending()) send_word($urandom_range(3) == 0, PB'($urandom));
    end
  endtask

  task automatic test_backpressure();
    set_frame(6, 5, 2);
    hold_ask = 3000;
    for (int i = 0; i < 30; i++) send_word(wmf_pkg::CMD_PUSH, PB'($urandom));
    wait_quiet();
    while (frame_pending()) send_word(wmf_pkg::CMD_DRAIN, PB'($urandom));
  endtask

  initial begin
    reg_width = 1024; reg_height = 1024; reg_half = 2;
    restart_frame();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    in_idle_pct = 16; out_idle_pct = 64;
    test_random_frames(110);
    in_idle_pct = 64; out_idle_pct = 16;
    test_random_frames(110);
    in_idle_pct = 0; out_idle_pct = 0;
    test_random_frames(110);
    test_backpressure();
    wait_quiet();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
